### rtl/jet_pkg.sv
// Shared types, constants and helper functions for the Julia escape-time pixel engine.
// Used by every module under rtl; depends on nothing else.
package jet_pkg;

  // Field widths
  localparam int COORD_BITS = 12;
  localparam int ITER_BITS  = 10;

  // Fixed-point formats: z is Q6.26, c is Q2.26, squares are Q12.52
  localparam int FRAC_BITS = 26;
  localparam int Q_W       = 32;
  localparam int C_W       = 28;
  localparam int RAD_W     = 57;
  localparam int MAXIT_W   = 10;
  localparam int PSTEP_W   = 27;
  localparam int SQ_W      = 2 * Q_W;

  // Start-point mapping: coordinate * step, plus origin, with headroom for the sign and carry
  localparam int MPROD_W = COORD_BITS + PSTEP_W;
  localparam int MAP_W   = MPROD_W + 2;

  // Next z before saturation: shifted square term plus c, with one carry bit
  localparam int NXT_W = SQ_W - (FRAC_BITS - 1) + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RAD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C_REAL         = 3'd0,
    REG_C_IMAG         = 3'd1,
    REG_RADIUS_SQ      = 3'd2,
    REG_MAX_ITERATIONS = 3'd3,
    REG_ORIGIN_REAL    = 3'd4,
    REG_ORIGIN_IMAG    = 3'd5,
    REG_PIXEL_STEP     = 3'd6
  } cfg_reg_t;

  // Register values after reset
  localparam logic signed [C_W-1:0]   C_REAL_RST         = -28'sd46976205;
  localparam logic signed [C_W-1:0]   C_IMAG_RST         = 28'sd18129460;
  localparam logic [RAD_W-1:0]        RADIUS_SQ_RST      = 57'h40000000000000;
  localparam logic [MAXIT_W-1:0]      MAX_ITERATIONS_RST = 10'd150;
  localparam logic signed [Q_W-1:0]   ORIGIN_REAL_RST    = -32'sd98082186;
  localparam logic signed [Q_W-1:0]   ORIGIN_IMAG_RST    = -32'sd67108864;
  localparam logic [PSTEP_W-1:0]      PIXEL_STEP_RST     = 27'd206489;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh80000000;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
  } pixel_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_col;
    logic [COORD_BITS-1:0] out_row;
    logic [ITER_BITS-1:0]  iteration_count;
    logic                  inside_set;
  } pixel_out_t;

  typedef struct packed {
    logic signed [C_W-1:0] c_real;
    logic signed [C_W-1:0] c_imag;
    logic [RAD_W-1:0]      radius_sq;
    logic [MAXIT_W-1:0]    max_iterations;
    logic signed [Q_W-1:0] origin_real;
    logic signed [Q_W-1:0] origin_imag;
    logic [PSTEP_W-1:0]    pixel_step;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_SQUARE,
    ST_STEP
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic map_mul;
    logic map_add;
    logic square;
    logic step;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic stop;
  } ctl_stat_t;

  // Clamp a mapped start point to Q6.26
  function automatic logic signed [Q_W-1:0] sat_map(input logic signed [MAP_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[MAP_W-1:Q_W-1];
    all_zero = ~|v[MAP_W-1:Q_W-1];
    if (all_one || all_zero) begin
      return v[Q_W-1:0];
    end else if (v[MAP_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

  // Clamp a new z part to Q6.26
  function automatic logic signed [Q_W-1:0] sat_next(input logic signed [NXT_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[NXT_W-1:Q_W-1];
    all_zero = ~|v[NXT_W-1:Q_W-1];
    if (all_one || all_zero) begin
      return v[Q_W-1:0];
    end else if (v[NXT_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

### rtl/julia_escape_time_pixel.sv
// Julia set escape-time pixel engine: maps a pixel to a start point and counts iterations.
// Pixel in on start/busy, one result word out on a done strobe, register writes on cfg_*.
// Depends on jet_pkg, jet_cfg_regs, jet_ctrl and jet_datapath.
//
// A pixel word is taken at a clock edge with start high and busy low. The engine maps
// it to z0 = origin + coordinate * pixel_step in the map_mul and map_add states, then
// runs the loop z = z*z + c, with one square state for the three 32x32 products and one
// step state for the escape test and the z update per iteration. The loop ends when
// |z|^2 reaches radius_sq or the count reaches max_iterations. The result word is on
// result for exactly one cycle with done high, the cycle after the final test; busy is
// already low in that cycle. A new pixel can be taken at the edge that ends the cycle
// done is shown; no new pixel is taken while one is still in the loop.
// Registers are written on cfg_valid/cfg_ready (ready always high); the user must write
// them only while idle, which the block itself does not enforce. Indexes beyond the list
// are ignored. Reset (rst, synchronous) returns the engine to idle and loads the default
// register values. There is no back-pressure on results.
module julia_escape_time_pixel (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  jet_pkg::pixel_in_t             pixel,
  output logic                           done,
  output jet_pkg::pixel_out_t            result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jet_pkg::CFG_DATA_W-1:0] cfg_data
);

  jet_pkg::cfg_t      cfg;
  jet_pkg::ctl_cmd_t  cmd;
  jet_pkg::ctl_stat_t stat;

  jet_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jet_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  jet_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pixel  (pixel),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

  // The result strobe only follows the final test, when the engine has gone idle
  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted pixel did not start the engine");

  a_inside_count: assert property (@(posedge clk) disable iff (rst)
    cmd.step && stat.stop && $stable(cfg.max_iterations) |=> done)
    else $error("final test gave no result");

endmodule

### rtl/jet_cfg_regs.sv
// Configuration register file for the Julia escape-time pixel engine.
// Depends on jet_pkg for the register indexes, widths and reset values.
module jet_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jet_pkg::CFG_DATA_W-1:0] cfg_data,
  output jet_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c_real         <= jet_pkg::C_REAL_RST;
      cfg.c_imag         <= jet_pkg::C_IMAG_RST;
      cfg.radius_sq      <= jet_pkg::RADIUS_SQ_RST;
      cfg.max_iterations <= jet_pkg::MAX_ITERATIONS_RST;
      cfg.origin_real    <= jet_pkg::ORIGIN_REAL_RST;
      cfg.origin_imag    <= jet_pkg::ORIGIN_IMAG_RST;
      cfg.pixel_step     <= jet_pkg::PIXEL_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (jet_pkg::cfg_reg_t'(cfg_index))
        jet_pkg::REG_C_REAL:         cfg.c_real <= signed'(cfg_data[jet_pkg::C_W-1:0]);
        jet_pkg::REG_C_IMAG:         cfg.c_imag <= signed'(cfg_data[jet_pkg::C_W-1:0]);
        jet_pkg::REG_RADIUS_SQ:      cfg.radius_sq <= cfg_data[jet_pkg::RAD_W-1:0];
        jet_pkg::REG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data[jet_pkg::MAXIT_W-1:0];
        jet_pkg::REG_ORIGIN_REAL:    cfg.origin_real <= signed'(cfg_data[jet_pkg::Q_W-1:0]);
        jet_pkg::REG_ORIGIN_IMAG:    cfg.origin_imag <= signed'(cfg_data[jet_pkg::Q_W-1:0]);
        jet_pkg::REG_PIXEL_STEP:     cfg.pixel_step <= cfg_data[jet_pkg::PSTEP_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

endmodule

### rtl/jet_datapath.sv
// Datapath of the Julia escape-time pixel engine: start-point mapping, squaring and z update.
// Depends on jet_pkg; driven by commands from jet_ctrl.
module jet_datapath (
  input  logic               clk,
  input  logic               rst,
  input  jet_pkg::cfg_t      cfg,
  input  jet_pkg::pixel_in_t pixel,
  input  jet_pkg::ctl_cmd_t  cmd,
  output jet_pkg::ctl_stat_t stat,
  output logic               done,
  output jet_pkg::pixel_out_t result
);

  logic [jet_pkg::COORD_BITS-1:0]     col;
  logic [jet_pkg::COORD_BITS-1:0]     row;
  logic [jet_pkg::MPROD_W-1:0]        prod_re;
  logic [jet_pkg::MPROD_W-1:0]        prod_im;
  logic signed [jet_pkg::Q_W-1:0]     zx;
  logic signed [jet_pkg::Q_W-1:0]     zy;
  logic [jet_pkg::SQ_W-1:0]           xx;
  logic [jet_pkg::SQ_W-1:0]           yy;
  logic signed [jet_pkg::SQ_W-1:0]    xy;
  logic [jet_pkg::MAXIT_W-1:0]        count;

  logic signed [jet_pkg::SQ_W-1:0]    mul_xx;
  logic signed [jet_pkg::SQ_W-1:0]    mul_yy;
  logic signed [jet_pkg::SQ_W-1:0]    mul_xy;
  logic signed [jet_pkg::MAP_W-1:0]   map_re;
  logic signed [jet_pkg::MAP_W-1:0]   map_im;
  logic [jet_pkg::SQ_W-1:0]           mag_sq;
  logic signed [jet_pkg::SQ_W-1:0]    diff;
  logic signed [jet_pkg::NXT_W-1:0]   nx_full;
  logic signed [jet_pkg::NXT_W-1:0]   ny_full;

  assign mul_xx = jet_pkg::SQ_W'(zx) * jet_pkg::SQ_W'(zx);
  assign mul_yy = jet_pkg::SQ_W'(zy) * jet_pkg::SQ_W'(zy);
  assign mul_xy = jet_pkg::SQ_W'(zx) * jet_pkg::SQ_W'(zy);

  assign map_re = signed'(jet_pkg::MAP_W'(prod_re)) + jet_pkg::MAP_W'(cfg.origin_real);
  assign map_im = signed'(jet_pkg::MAP_W'(prod_im)) + jet_pkg::MAP_W'(cfg.origin_imag);

  // Squares are never negative, so |z|^2 is exact as an unsigned sum
  assign mag_sq = xx + yy;
  assign diff   = signed'(xx) - signed'(yy);

  // Arithmetic right shifts round toward minus infinity; the doubling folds into the shift
  assign nx_full = jet_pkg::NXT_W'(signed'(diff[jet_pkg::SQ_W-1:jet_pkg::FRAC_BITS]))
                 + jet_pkg::NXT_W'(cfg.c_real);
  assign ny_full = jet_pkg::NXT_W'(signed'(xy[jet_pkg::SQ_W-1:jet_pkg::FRAC_BITS-1]))
                 + jet_pkg::NXT_W'(cfg.c_imag);

  assign stat.stop = (count >= cfg.max_iterations)
                   || (mag_sq >= jet_pkg::SQ_W'(cfg.radius_sq));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col   <= pixel.pixel_col;
      row   <= pixel.pixel_row;
      count <= '0;
    end
    if (cmd.map_mul) begin
      prod_re <= jet_pkg::MPROD_W'(col) * jet_pkg::MPROD_W'(cfg.pixel_step);
      prod_im <= jet_pkg::MPROD_W'(row) * jet_pkg::MPROD_W'(cfg.pixel_step);
    end
    if (cmd.map_add) begin
      zx <= jet_pkg::sat_map(map_re);
      zy <= jet_pkg::sat_map(map_im);
    end
    if (cmd.square) begin
      xx <= unsigned'(mul_xx);
      yy <= unsigned'(mul_yy);
      xy <= mul_xy;
    end
    if (cmd.step && !stat.stop) begin
      zx    <= jet_pkg::sat_next(nx_full);
      zy    <= jet_pkg::sat_next(ny_full);
      count <= count + jet_pkg::MAXIT_W'(1);
    end
    if (cmd.step && stat.stop) begin
      result.out_col         <= col;
      result.out_row         <= row;
      result.iteration_count <= jet_pkg::ITER_BITS'(count);
      result.inside_set      <= (count == cfg.max_iterations);
    end
  end

  // Result strobe lasts one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.step && stat.stop;
    end
  end

endmodule

### rtl/jet_ctrl.sv
// Controller state machine of the Julia escape-time pixel engine.
// Depends on jet_pkg; sequences jet_datapath through mapping and the iteration loop.
module jet_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  jet_pkg::ctl_stat_t stat,
  output jet_pkg::ctl_cmd_t  cmd
);

  jet_pkg::state_t state;
  jet_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jet_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      jet_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = jet_pkg::ST_MAP_MUL;
        end
      end
      jet_pkg::ST_MAP_MUL: begin
        cmd.map_mul = 1'b1;
        state_next  = jet_pkg::ST_MAP_ADD;
      end
      jet_pkg::ST_MAP_ADD: begin
        cmd.map_add = 1'b1;
        state_next  = jet_pkg::ST_SQUARE;
      end
      jet_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = jet_pkg::ST_STEP;
      end
      jet_pkg::ST_STEP: begin
        // Either advance z and go round again, or hand the word out
        cmd.step = 1'b1;
        if (stat.stop) begin
          state_next = jet_pkg::ST_IDLE;
        end else begin
          state_next = jet_pkg::ST_SQUARE;
        end
      end
      default: begin
        state_next = jet_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### tb/julia_escape_time_pixel_test.sv
// Self-checking bench for the Julia escape-time pixel engine: random and directed pixel words
// against an in-bench fixed-point escape-time predictor, across several register settings.
// Depends on jet_pkg and julia_escape_time_pixel.
module julia_escape_time_pixel_test;

  timeunit 1ns;
  timeprecision 1ps;

  // Index past the end of the register list; writes to it must be dropped
  localparam logic [jet_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int REG_WIDTH [0:6] = '{jet_pkg::C_W, jet_pkg::C_W, jet_pkg::RAD_W,
                                     jet_pkg::MAXIT_W, jet_pkg::Q_W, jet_pkg::Q_W,
                                     jet_pkg::PSTEP_W};
  localparam int MAX_GAP = 18;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           start     = 1'b0;
  jet_pkg::pixel_in_t             pixel     = '0;
  logic                           cfg_valid = 1'b0;
  logic [jet_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [jet_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                           busy;
  logic                           done;
  logic                           cfg_ready;
  jet_pkg::pixel_out_t            result;

  // Bench copy of the register file
  longint          set_c_re;
  longint          set_c_im;
  longint unsigned set_radius_sq;
  int unsigned     set_iter_cap;
  longint          set_origin_re;
  longint          set_origin_im;
  longint          set_step;

  jet_pkg::pixel_in_t  pixel_backlog[$];
  jet_pkg::pixel_out_t pending_escapes[$];
  int         idle_left = 0;
  int         gap_ceiling = MAX_GAP;
  int         failures = 0;
  int         items_sent = 0;
  int         results_checked = 0;
  int         inside_seen = 0;
  int         settings_loaded = 0;

  julia_escape_time_pixel dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_q(longint v);
    if (v > longint'(jet_pkg::Q_MAX)) return longint'(jet_pkg::Q_MAX);
    if (v < longint'(jet_pkg::Q_MIN)) return longint'(jet_pkg::Q_MIN);
    return v;
  endfunction

  function automatic jet_pkg::pixel_out_t escape_time_of(jet_pkg::pixel_in_t px);
    jet_pkg::pixel_out_t r;
    longint          zx, zy, ax, ay, diff, prod, nx, ny;
    longint unsigned xx, yy;
    int unsigned     n;
    zx = clamp_q(set_origin_re + longint'(px.pixel_col) * set_step);
    zy = clamp_q(set_origin_im + longint'(px.pixel_row) * set_step);
    n = 0;
    while (n < set_iter_cap) begin
      ax = (zx < 0) ? -zx : zx;
      ay = (zy < 0) ? -zy : zy;
      xx = ax * ax;
      yy = ay * ay;
      if (xx + yy >= set_radius_sq) break;
      diff = longint'(xx) - longint'(yy);
      prod = zx * zy;
      // floor shifts; the cross term loses one bit less to double it
      nx = clamp_q((diff >>> jet_pkg::FRAC_BITS) + set_c_re);
      ny = clamp_q((prod >>> (jet_pkg::FRAC_BITS - 1)) + set_c_im);
      zx = nx;
      zy = ny;
      n++;
    end
    r.out_col         = px.pixel_col;
    r.out_row         = px.pixel_row;
    r.iteration_count = n[jet_pkg::ITER_BITS-1:0];
    r.inside_set      = (n == set_iter_cap);
    return r;
  endfunction

  function automatic void apply_reg(logic [jet_pkg::CFG_IDX_W-1:0] idx,
                                    logic [jet_pkg::CFG_DATA_W-1:0] d);
    logic signed [jet_pkg::C_W-1:0] c_part;
    logic signed [jet_pkg::Q_W-1:0] q_part;
    c_part = d[jet_pkg::C_W-1:0];
    q_part = d[jet_pkg::Q_W-1:0];
    case (idx)
      jet_pkg::REG_C_REAL:         set_c_re = longint'(c_part);
      jet_pkg::REG_C_IMAG:         set_c_im = longint'(c_part);
      jet_pkg::REG_RADIUS_SQ:      set_radius_sq = 64'(d[jet_pkg::RAD_W-1:0]);
      jet_pkg::REG_MAX_ITERATIONS: set_iter_cap = 32'(d[jet_pkg::MAXIT_W-1:0]);
      jet_pkg::REG_ORIGIN_REAL:    set_origin_re = longint'(q_part);
      jet_pkg::REG_ORIGIN_IMAG:    set_origin_im = longint'(q_part);
      jet_pkg::REG_PIXEL_STEP:     set_step = 64'(d[jet_pkg::PSTEP_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  // Driver: hold a word until taken, then idle for the drawn number of cycles
  always @(posedge clk) begin : driver
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy)
        pending_escapes.push_back(escape_time_of(pixel));
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          start <= 1'b1;
          pixel <= pixel_backlog.pop_front();
          idle_left = $urandom_range(0, gap_ceiling);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    jet_pkg::pixel_out_t want;
    if (!rst && done) begin
      if (pending_escapes.size() == 0) begin
        $display("%0t ns: result word with nothing outstanding: col %0d row %0d count %0d",
                 $time, result.out_col, result.out_row, result.iteration_count);
        failures++;
      end else begin
        want = pending_escapes.pop_front();
        check_field("out_col", want.out_col, result.out_col);
        check_field("out_row", want.out_row, result.out_row);
        check_field("iteration_count", want.iteration_count, result.iteration_count);
        check_field("inside_set", want.inside_set, result.inside_set);
        results_checked++;
        if (result.inside_set === 1'b1) inside_seen++;
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || start || busy || pending_escapes.size() != 0);
  endtask

  // One register word; upper bits beyond the field are sometimes filled with noise
  task automatic cfg_write(logic [jet_pkg::CFG_IDX_W-1:0] idx,
                           logic [jet_pkg::CFG_DATA_W-1:0] data);
    logic [jet_pkg::CFG_DATA_W-1:0] word;
    logic [jet_pkg::CFG_DATA_W-1:0] keep;
    word = data;
    if (idx != REG_UNUSED && $urandom_range(0, 3) == 0) begin
      keep = (jet_pkg::CFG_DATA_W'(1) << REG_WIDTH[idx]) - 1'b1;
      word = (word & keep) | (jet_pkg::CFG_DATA_W'({$urandom, $urandom}) & ~keep);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk);
    while (!cfg_ready);
    apply_reg(idx, word);
  endtask

  task automatic load_settings(longint c_re, longint c_im, longint unsigned rad,
                               int unsigned iter_cap, longint o_re, longint o_im,
                               longint unsigned stp, bit stray);
    wait_idle();
    @(posedge clk);
    if (stray) cfg_write(REG_UNUSED, jet_pkg::CFG_DATA_W'({$urandom, $urandom}));
    cfg_write(jet_pkg::REG_C_REAL, jet_pkg::CFG_DATA_W'(c_re));
    cfg_write(jet_pkg::REG_C_IMAG, jet_pkg::CFG_DATA_W'(c_im));
    cfg_write(jet_pkg::REG_RADIUS_SQ, jet_pkg::CFG_DATA_W'(rad));
    cfg_write(jet_pkg::REG_MAX_ITERATIONS, jet_pkg::CFG_DATA_W'(iter_cap));
    cfg_write(jet_pkg::REG_ORIGIN_REAL, jet_pkg::CFG_DATA_W'(o_re));
    cfg_write(jet_pkg::REG_ORIGIN_IMAG, jet_pkg::CFG_DATA_W'(o_im));
    cfg_write(jet_pkg::REG_PIXEL_STEP, jet_pkg::CFG_DATA_W'(stp));
    cfg_valid <= 1'b0;
    @(negedge clk);
    settings_loaded++;
  endtask

  task automatic send_pixel(int unsigned col, int unsigned row);
    jet_pkg::pixel_in_t px;
    px.pixel_col = jet_pkg::COORD_BITS'(col);
    px.pixel_row = jet_pkg::COORD_BITS'(row);
    pixel_backlog.push_back(px);
    items_sent++;
  endtask

  initial begin
    longint          c_re, c_im, o_re, o_im;
    longint unsigned rad, stp;
    int unsigned     frame_w, iter_cap, batch, pick, random_goal;
    bit              framed;

    set_c_re      = longint'(jet_pkg::C_REAL_RST);
    set_c_im      = longint'(jet_pkg::C_IMAG_RST);
    set_radius_sq = 64'(jet_pkg::RADIUS_SQ_RST);
    set_iter_cap  = 32'(jet_pkg::MAX_ITERATIONS_RST);
    set_origin_re = longint'(jet_pkg::ORIGIN_REAL_RST);
    set_origin_im = longint'(jet_pkg::ORIGIN_IMAG_RST);
    set_step      = 64'(jet_pkg::PIXEL_STEP_RST);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Values after reset: corners, bit patterns and the middle of the view
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(475, 325);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);

    // Zero iteration limit
    load_settings(jet_pkg::C_REAL_RST, jet_pkg::C_IMAG_RST, jet_pkg::RADIUS_SQ_RST, 0,
                  jet_pkg::ORIGIN_REAL_RST, jet_pkg::ORIGIN_IMAG_RST,
                  jet_pkg::PIXEL_STEP_RST, 1'b0);
    send_pixel(475, 325);
    send_pixel(0, 0);

    // Field extremes; start point clamps at the top of the range
    load_settings((longint'(1) << 27) - 1, -(longint'(1) << 27), (longint'(1) << 57) - 1, 1,
                  jet_pkg::Q_MAX, jet_pkg::Q_MIN, (longint'(1) << 27) - 1, 1'b1);
    send_pixel(4095, 4095);
    send_pixel(0, 0);
    send_pixel(4095, 0);

    // Empty escape radius
    load_settings(jet_pkg::C_REAL_RST, jet_pkg::C_IMAG_RST, 0, 1023,
                  jet_pkg::ORIGIN_REAL_RST, jet_pkg::ORIGIN_IMAG_RST,
                  jet_pkg::PIXEL_STEP_RST, 1'b0);
    send_pixel(475, 325);

    // Longest loop around the origin
    load_settings(jet_pkg::C_REAL_RST, jet_pkg::C_IMAG_RST, jet_pkg::RADIUS_SQ_RST, 1023,
                  0, 0, 1, 1'b0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(100, 100);

    // c = -2 settles at z = 2, which sits exactly on a radius of two
    load_settings(-(longint'(1) << 27), 0, (longint'(1) << 57) - 1, 1023, 0, 0, 1, 1'b0);
    send_pixel(0, 0);
    send_pixel(1, 0);
    load_settings(-(longint'(1) << 27), 0, jet_pkg::RADIUS_SQ_RST, 1023, 0, 0, 1, 1'b0);
    send_pixel(0, 0);

    random_goal = items_sent + 820;
    while (items_sent < random_goal) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) iter_cap = $urandom_range(301, 1023);
      else if (pick == 1) iter_cap = $urandom_range(0, 3);
      else iter_cap = $urandom_range(4, 250);

      if ($urandom_range(0, 4) != 0) begin
        c_re = longint'($urandom_range(0, 201326592)) - 100663296;
        c_im = longint'($urandom_range(0, 201326592)) - 100663296;
      end else begin
        c_re = longint'($urandom);
        c_im = longint'($urandom);
      end

      pick = $urandom_range(0, 19);
      if (pick < 12) rad = 64'(jet_pkg::RADIUS_SQ_RST);
      else if (pick < 17)
        rad = 64'd10133099161583616 +
              ({$urandom, $urandom} % (64'd72057594037927936 - 64'd10133099161583616 + 1));
      else rad = {$urandom, $urandom} & ((64'd1 << jet_pkg::RAD_W) - 1);

      // Mostly a frame of 8 to 400 pixels a side spanning the interesting square
      framed = ($urandom_range(0, 19) < 17);
      frame_w = $urandom_range(8, 400);
      if (framed) begin
        stp  = (longint'(4) << jet_pkg::FRAC_BITS) / frame_w;
        o_re = -(longint'(2) << jet_pkg::FRAC_BITS) + longint'($urandom_range(0, 1 << 25))
               - (1 << 24);
        o_im = -(longint'(2) << jet_pkg::FRAC_BITS) + longint'($urandom_range(0, 1 << 25))
               - (1 << 24);
      end else begin
        stp  = 64'($urandom_range(1, (1 << 27) - 1));
        o_re = longint'(int'($urandom));
        o_im = longint'(int'($urandom));
      end

      load_settings(c_re, c_im, rad, iter_cap, o_re, o_im, stp, $urandom_range(0, 4) == 0);
      gap_ceiling = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      batch = (iter_cap > 300) ? $urandom_range(5, 15) : $urandom_range(30, 70);
      repeat (batch) begin
        if ($urandom_range(0, 19) < 17)
          send_pixel($urandom_range(0, frame_w), $urandom_range(0, frame_w));
        else
          send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d pixel words under %0d register settings after reset.",
             items_sent, settings_loaded);
    $display("Checked %0d results, %0d of them inside the set.", results_checked, inside_seen);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Timed out with %0d results outstanding", pending_escapes.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
rtl/jet_pkg.sv
rtl/jet_cfg_regs.sv
rtl/jet_datapath.sv
rtl/jet_ctrl.sv
rtl/julia_escape_time_pixel.sv
tb/julia_escape_time_pixel_test.sv
